// ===== design/ptd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_pkg: shared constants and types for the priority task dispatcher
// Queue and nesting sizes, opcode and status codes, field widths.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int QUEUE_DEPTH = 16;   // power of two, circular addressing
	localparam int NEST_DEPTH  = 8;

	localparam int QA_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int NST_W  = $clog2(NEST_DEPTH + 1);
	localparam int NST_AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

	localparam int PRIO_W  = 8;
	localparam int TAG_W   = 16;
	localparam int LEVEL_W = 9;
	localparam int ENTRY_W = PRIO_W + TAG_W;

	localparam logic signed [LEVEL_W-1:0] IDLE_LEVEL = -9'sd1;

	localparam logic [1:0] FN_ADD      = 2'd0;
	localparam logic [1:0] FN_DISPATCH = 2'd1;
	localparam logic [1:0] FN_FINISH   = 2'd2;

	localparam logic [2:0] ST_ADDED       = 3'd0;
	localparam logic [2:0] ST_DISPATCHED  = 3'd1;
	localparam logic [2:0] ST_NONE        = 3'd2;
	localparam logic [2:0] ST_FULL        = 3'd3;
	localparam logic [2:0] ST_FINISHED    = 3'd4;
	localparam logic [2:0] ST_IDLE_FINISH = 3'd5;
	localparam logic [2:0] ST_NEST_FULL   = 3'd6;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

endpackage

// ===== design/priority_task_dispatcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_dispatcher: nested priority task dispatcher
// Sorted task queue in a small memory, nesting stack of saved run levels.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* takes one command per transaction: s_tuser selects add,
//   dispatch or finish; s_tdata carries the priority and tag of an added task.
//   Master channel m_* returns exactly one result per command: m_tuser holds
//   the status, m_tdata the dispatched task, running level and queue count.
//   One command is in flight at a time; s_tready is high only when idle.
//   From acceptance, finish passes through the execute and done states;
//   dispatch adds a check of the queue head; add adds a check state and
//   compare steps that shift each lower-priority queued task one place back.
//   Idle follows before the next command is taken. The sorted insert walks
//   the queue memory one entry per cycle from the tail through a single
//   compare and one read and one write port; that walk sets the throughput.
//   A stalled m_tready holds the result in the output register; the block
//   finishes its next command and then waits until the register frees up.
//   Reset empties the queue and the stack and sets the level to idle (-1);
//   memory contents are not cleared, as only filled entries are ever used.
// ----------------------------------------------------------------------------
module priority_task_dispatcher
	import ptd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] priority_req, [23:8] task_tag
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] out_tag, [23:16] out_priority,
	                               // [32:24] running_level, [37:33] queued_count
	output logic [2:0]  m_tuser    // [2:0] status
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_DSP  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]                  state_q;
	logic [1:0]                  func_q;
	entry_t                      req_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            idx_q;
	logic [QA_W-1:0]             base_q;
	logic signed [LEVEL_W-1:0]   level_q;
	logic [NST_W-1:0]            nest_q;
	logic [2:0]                  status_q;
	logic [TAG_W-1:0]            otag_q;
	logic [PRIO_W-1:0]           oprio_q;

	logic                        m_tvalid_q;
	logic [2:0]                  m_status_q;
	logic [TAG_W-1:0]            m_tag_q;
	logic [PRIO_W-1:0]           m_prio_q;
	logic signed [LEVEL_W-1:0]   m_level_q;
	logic [4:0]                  m_count_q;

	entry_t                      queue_mem [QUEUE_DEPTH];
	entry_t                      rd_data_q;
	logic [QA_W-1:0]             rd_addr;
	logic                        wr_en;
	logic [QA_W-1:0]             wr_addr;
	entry_t                      wr_data;

	logic signed [LEVEL_W-1:0]   saved_mem [NEST_DEPTH];
	logic signed [LEVEL_W-1:0]   saved_rd_q;
	logic                        push_en;

	logic [CNT_W-1:0]            idx_m1;
	logic [CNT_W-1:0]            idx_m2;
	logic [NST_W-1:0]            nest_m1;
	logic                        stop_shift;
	logic                        out_free;
	logic                        out_load;
	logic                        head_eligible;

	assign idx_m1        = idx_q - 1'b1;
	assign idx_m2        = idx_q - 2'd2;
	assign nest_m1       = nest_q - 1'b1;
	assign stop_shift    = rd_data_q.prio >= req_q.prio;
	assign out_free      = !m_tvalid_q || m_tready;
	assign out_load      = (state_q == S_DONE) && out_free;
	assign head_eligible = $signed({1'b0, rd_data_q.prio}) > level_q;
	assign s_tready      = (state_q == S_IDLE);
	assign push_en       = (state_q == S_DSP) && head_eligible &&
	                       (nest_q < NST_W'(NEST_DEPTH));

	always_comb begin
		rd_addr = base_q;
		wr_en   = 1'b0;
		wr_addr = base_q + idx_q[QA_W-1:0];
		wr_data = req_q;
		unique case (state_q)
			S_CHK: begin
				rd_addr = base_q + idx_m1[QA_W-1:0];
				wr_en   = (idx_q == '0);
			end
			S_CMP: begin
				rd_addr = base_q + idx_m2[QA_W-1:0];
				wr_en   = 1'b1;
				if (!stop_shift) begin
					wr_data = rd_data_q;
				end
			end
			default: begin
				rd_addr = base_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= queue_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			saved_mem[nest_q[NST_AW-1:0]] <= level_q;
		end
		saved_rd_q <= saved_mem[nest_m1[NST_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			base_q     <= '0;
			level_q    <= IDLE_LEVEL;
			nest_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						func_q     <= s_tuser;
						req_q.prio <= s_tdata[7:0];
						req_q.tag  <= s_tdata[23:8];
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					otag_q   <= '0;
					oprio_q  <= '0;
					case (func_q)
						FN_ADD: begin
							if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								idx_q   <= count_q;
								state_q <= S_CHK;
							end
						end
						FN_DISPATCH: begin
							if (count_q != '0) begin
								state_q <= S_DSP;
							end else begin
								status_q <= ST_NONE;
								state_q  <= S_DONE;
							end
						end
						FN_FINISH: begin
							state_q <= S_DONE;
							if (nest_q == '0) begin
								status_q <= ST_IDLE_FINISH;
							end else begin
								nest_q   <= nest_m1;
								level_q  <= saved_rd_q;
								status_q <= ST_FINISHED;
							end
						end
						default: begin
							status_q <= ST_NONE;
							state_q  <= S_DONE;
						end
					endcase
				end
				S_CHK: begin
					if (idx_q == '0) begin
						count_q  <= count_q + 1'b1;
						status_q <= ST_ADDED;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (stop_shift) begin
						count_q  <= count_q + 1'b1;
						status_q <= ST_ADDED;
						state_q  <= S_DONE;
					end else begin
						idx_q <= idx_m1;
						if (idx_m1 == '0) begin
							state_q <= S_CHK;
						end
					end
				end
				S_DSP: begin
					state_q <= S_DONE;
					if (!head_eligible) begin
						status_q <= ST_NONE;
					end else if (!push_en) begin
						status_q <= ST_NEST_FULL;
					end else begin
						base_q   <= base_q + 1'b1;
						count_q  <= count_q - 1'b1;
						nest_q   <= nest_q + 1'b1;
						level_q  <= $signed({1'b0, rd_data_q.prio});
						otag_q   <= rd_data_q.tag;
						oprio_q  <= rd_data_q.prio;
						status_q <= ST_DISPATCHED;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_status_q <= status_q;
						m_tag_q    <= otag_q;
						m_prio_q   <= oprio_q;
						m_level_q  <= level_q;
						m_count_q  <= 5'(count_q);
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {2'b00, m_count_q, m_level_q, m_prio_q, m_tag_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_nest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nest_q <= NST_W'(NEST_DEPTH))
		else $error("nesting depth above limit");

	a_dispatch_level: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_status_q == ST_DISPATCHED) |->
		(m_level_q == $signed({1'b0, m_prio_q})))
		else $error("dispatched priority differs from running level");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> m_tvalid_q)
		else $error("finished transaction did not reach output register");

	a_idle_nest: assert property (@(posedge clk) disable iff (!arst_n)
		(nest_q == '0) |-> (level_q == IDLE_LEVEL))
		else $error("empty nesting stack with non-idle level");

endmodule
